/* rtl/chs_lba_pkg.sv */
// Package: request, result and pipeline word types for the CHS/LBA converter.
package chs_lba_pkg;

    localparam int K_GEOM_W    = 16;
    localparam int K_LBA_IN_W  = 31;
    localparam int K_LBA_OUT_W = 48;
    localparam int K_CYL_W     = 10;
    localparam int K_SEC_W     = 6;
    localparam int K_PCYL_W    = 2 * K_GEOM_W;
    localparam int K_DIV_W     = K_PCYL_W + K_CYL_W - 1;
    localparam int K_HC_W      = K_GEOM_W + K_CYL_W;
    localparam int K_SUM_W     = K_HC_W + 1;
    localparam int K_PROD_W    = K_SUM_W + K_GEOM_W;
    localparam int K_CYL_CELLS  = K_CYL_W;
    localparam int K_HEAD_CELLS = K_GEOM_W;

    localparam logic [K_CYL_W-1:0]  K_CYL_MAX      = 10'd1023;
    localparam logic [K_GEOM_W-1:0] K_GEOM_UNKNOWN = 16'hFFFF;
    localparam logic [7:0]          K_CYL_HI_MASK  = 8'hC0;
    localparam logic [7:0]          K_SECT_MASK    = 8'h3F;

    localparam logic K_REG_HEADS = 1'b0;
    localparam logic K_REG_SPT   = 1'b1;
    localparam logic K_REQ_CHS_TO_LBA = 1'b0;

    typedef struct packed {
        logic                  req_type;
        logic [K_LBA_IN_W-1:0] lba_in;
        logic [7:0]            head_byte_in;
        logic [7:0]            sector_byte_in;
        logic [7:0]            cylinder_byte_in;
    } t_req;

    typedef struct packed {
        logic [K_LBA_OUT_W-1:0] lba_out;
        logic [7:0]             head_byte_out;
        logic [7:0]             sector_byte_out;
        logic [7:0]             cylinder_byte_out;
    } t_rsp;

    typedef struct packed {
        logic                req_type;
        logic                clamp;
        logic                bad;
        logic [K_SEC_W-1:0]  sec;
        logic [K_PROD_W-1:0] prod;
        logic [K_GEOM_W-1:0] spt;
        logic [K_GEOM_W-1:0] heads;
        logic [K_CYL_W-1:0]  cyl;
    } t_side;

    typedef struct packed {
        logic                  valid;
        logic [K_LBA_IN_W-1:0] rem;
        logic [K_DIV_W-1:0]    div;
        logic [K_GEOM_W-1:0]   q;
        t_side                 side;
    } t_cell_word;

endpackage

/* rtl/chs_lba_cell.sv */
// Divider cell: one restoring quotient bit, hands the word to the next cell.
module chs_lba_cell
    import chs_lba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_word i_word,
    output t_cell_word o_word
);

    t_cell_word r_word;
    t_cell_word n_word;
    logic       w_ge;

    always_comb begin
        w_ge   = {{(K_DIV_W-K_LBA_IN_W){1'b0}}, i_word.rem} >= i_word.div;
        n_word = i_word;
        n_word.div = i_word.div >> 1;
        n_word.q   = {i_word.q[K_GEOM_W-2:0], w_ge};
        if (w_ge) begin
            n_word.rem = i_word.rem - i_word.div[K_LBA_IN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/chs_lba_converter_unit.sv */
// Top level: CHS/LBA address converter built as a chain of divider cells.
//
// Request channel: i_valid/i_req in, o_stall out; a word is taken when
// i_valid is high and o_stall is low. Result channel: o_valid/o_rsp out,
// i_stall in; a word leaves when o_valid is high and i_stall is low.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 heads,
// 1 sectors per track) and i_cfg_data; o_cfg_ready is always high.
// Every request yields one result. The path is three setup stages (input
// capture, geometry product with CHS multiply, range check), ten cylinder
// cells, a reload stage, sixteen head cells and the output register.
// One request is taken per cycle while o_stall is low.
// Reset empties the pipeline and loads heads 16 and sectors per track 63.
// A stall with a result waiting freezes the whole chain and raises o_stall.
module chs_lba_converter_unit
    import chs_lba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_req                i_req,
    output logic                o_stall,
    output logic                o_valid,
    output t_rsp                o_rsp,
    input  logic                i_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [K_GEOM_W-1:0] i_cfg_data
);

    logic [K_GEOM_W-1:0] r_heads;
    logic [K_GEOM_W-1:0] r_spt;

    logic                w_en;

    logic                r_s0_valid;
    t_req                r_s0_req;
    logic [K_GEOM_W-1:0] r_s0_heads;
    logic [K_GEOM_W-1:0] r_s0_spt;

    logic                  r_s1_valid;
    t_req                  r_s1_req;
    logic [K_GEOM_W-1:0]   r_s1_heads;
    logic [K_GEOM_W-1:0]   r_s1_spt;
    logic [K_PCYL_W-1:0]   r_s1_pcyl;
    logic [K_HC_W-1:0]     r_s1_hc;
    logic                  r_s1_bad;
    logic [K_CYL_W-1:0]    w_s0_cyl;
    logic [K_SEC_W-1:0]    w_s0_sec;

    t_cell_word w_s2;
    t_cell_word r_s2;
    t_cell_word w_cyl  [0:K_CYL_CELLS];
    t_cell_word w_mid;
    t_cell_word r_mid;
    t_cell_word w_head [0:K_HEAD_CELLS];

    logic                r_out_valid;
    t_rsp                r_out;
    t_rsp                n_out;
    t_cell_word          w_fin;
    logic [K_CYL_W-1:0]  w_fin_cyl;
    logic [K_GEOM_W-1:0] w_fin_head;
    logic [K_GEOM_W-1:0] w_fin_sec;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !(r_out_valid && i_stall);
    assign o_stall     = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads <= 16'd16;
            r_spt   <= 16'd63;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                K_REG_HEADS: r_heads <= i_cfg_data;
                K_REG_SPT:   r_spt   <= i_cfg_data;
                default:     r_heads <= r_heads;
            endcase
        end
    end

    assign w_s0_cyl = {r_s0_req.sector_byte_in[7:6], r_s0_req.cylinder_byte_in};
    assign w_s0_sec = r_s0_req.sector_byte_in[K_SEC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
        end
        if (w_en) begin
            r_s0_req   <= i_req;
            r_s0_heads <= r_heads;
            r_s0_spt   <= r_spt;
            r_s1_req   <= r_s0_req;
            r_s1_heads <= r_s0_heads;
            r_s1_spt   <= r_s0_spt;
            r_s1_pcyl  <= {{(K_PCYL_W-K_GEOM_W){1'b0}}, r_s0_spt}
                        * {{(K_PCYL_W-K_GEOM_W){1'b0}}, r_s0_heads};
            r_s1_hc    <= {{(K_HC_W-K_GEOM_W){1'b0}}, r_s0_heads}
                        * {{(K_HC_W-K_CYL_W){1'b0}}, w_s0_cyl};
            r_s1_bad   <= (w_s0_cyl == K_CYL_MAX) || (w_s0_sec == '0)
                       || (r_s0_spt == K_GEOM_UNKNOWN) || (r_s0_heads == K_GEOM_UNKNOWN);
        end
    end

    always_comb begin
        w_s2.valid          = r_s1_valid;
        w_s2.rem            = r_s1_req.lba_in;
        w_s2.div            = {r_s1_pcyl, {(K_CYL_W-1){1'b0}}};
        w_s2.q              = '0;
        w_s2.side.req_type  = r_s1_req.req_type;
        w_s2.side.clamp     = (r_s1_pcyl == '0)
                           || ({{(K_DIV_W+1-K_LBA_IN_W){1'b0}}, r_s1_req.lba_in}
                               >= {r_s1_pcyl, {K_CYL_W{1'b0}}});
        w_s2.side.bad       = r_s1_bad;
        w_s2.side.sec       = r_s1_req.sector_byte_in[K_SEC_W-1:0];
        w_s2.side.prod      = {{(K_PROD_W-K_GEOM_W){1'b0}}, r_s1_spt}
                            * {{(K_PROD_W-K_SUM_W){1'b0}},
                               ({{(K_SUM_W-8){1'b0}}, r_s1_req.head_byte_in}
                                + {1'b0, r_s1_hc})};
        w_s2.side.spt       = r_s1_spt;
        w_s2.side.heads     = r_s1_heads;
        w_s2.side.cyl       = {r_s1_req.sector_byte_in[7:6], r_s1_req.cylinder_byte_in};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (w_en) begin
            r_s2 <= w_s2;
        end
    end

    assign w_cyl[0] = r_s2;

    for (genvar g = 0; g < K_CYL_CELLS; g++) begin : g_cyl
        chs_lba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_cyl[g]),
            .o_word  (w_cyl[g+1])
        );
    end

    // reload the divisor with sectors per track for the head quotient
    always_comb begin
        w_mid          = w_cyl[K_CYL_CELLS];
        w_mid.side.cyl = w_cyl[K_CYL_CELLS].q[K_CYL_W-1:0];
        w_mid.q        = '0;
        w_mid.div      = {{(K_DIV_W-K_PCYL_W+1){1'b0}}, w_cyl[K_CYL_CELLS].side.spt,
                          {(K_GEOM_W-1){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
        end else if (w_en) begin
            r_mid <= w_mid;
        end
    end

    assign w_head[0] = r_mid;

    for (genvar g = 0; g < K_HEAD_CELLS; g++) begin : g_head
        chs_lba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_head[g]),
            .o_word  (w_head[g+1])
        );
    end

    assign w_fin = w_head[K_HEAD_CELLS];

    always_comb begin
        if (w_fin.side.clamp) begin
            w_fin_cyl  = K_CYL_MAX;
            w_fin_head = w_fin.side.heads - 16'd1;
            w_fin_sec  = w_fin.side.spt;
        end else begin
            w_fin_cyl  = w_fin.side.cyl;
            w_fin_head = w_fin.q;
            w_fin_sec  = w_fin.rem[K_GEOM_W-1:0] + 16'd1;
        end
        n_out = '0;
        if (w_fin.side.req_type == K_REQ_CHS_TO_LBA) begin
            if (!w_fin.side.bad) begin
                n_out.lba_out = {{(K_LBA_OUT_W-K_PROD_W){1'b0}}, w_fin.side.prod}
                              + {{(K_LBA_OUT_W-K_SEC_W){1'b0}}, w_fin.side.sec}
                              - {{(K_LBA_OUT_W-1){1'b0}}, 1'b1};
            end
        end else begin
            n_out.head_byte_out     = w_fin_head[7:0];
            n_out.sector_byte_out   = w_fin_sec[7:0]
                                    | ({w_fin_cyl[9:8], 6'b0} & K_CYL_HI_MASK);
            n_out.cylinder_byte_out = w_fin_cyl[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_fin.valid;
        end
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule
